// ----- hw/rtl/swbmwc_pkg.sv -----
// ----------------------------------------------------------------------------
// swbmwc_pkg
// Shared types and constants for the SWB/MWC random word generator.
// ----------------------------------------------------------------------------
package swbmwc_pkg;

  localparam int WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  // Request codes carried in the func field
  localparam logic FUNC_GENERATE = 1'b0;
  localparam logic FUNC_SEED     = 1'b1;

  // Seed offsets, also the state after reset
  localparam word_t INIT_A    = 32'd521288629;
  localparam word_t INIT_B    = 32'd362436069;
  localparam word_t INIT_C    = 32'd16163801;
  localparam word_t INIT_LOW  = 32'd1245364;
  localparam word_t INIT_HIGH = 32'd46347;

  // Multiply-with-carry multipliers
  localparam logic [15:0] MUL_LOW  = 16'd18000;
  localparam logic [15:0] MUL_HIGH = 16'd30903;

  // Seed scrambling multiplier and subtract-with-borrow offset
  localparam word_t SEED_MUL_LOW = 32'd23343;
  localparam word_t SWB_OFFSET   = 32'd18;

  typedef struct packed {
    word_t lag_a;
    word_t lag_b;
    word_t lag_c;
    logic  borrow;
    word_t mwc_low;
    word_t mwc_high;
  } gen_state_t;

  localparam gen_state_t STATE_RESET = '{
    lag_a:    INIT_A,
    lag_b:    INIT_B,
    lag_c:    INIT_C,
    borrow:   1'b1,
    mwc_low:  INIT_LOW,
    mwc_high: INIT_HIGH
  };

endpackage

// ----- hw/rtl/swbmwc_if.sv -----
// ----------------------------------------------------------------------------
// swbmwc_if
// Valid/ready channels for requests and random words.
// ----------------------------------------------------------------------------
interface swbmwc_in_if;
  import swbmwc_pkg::*;

  logic  valid;
  logic  ready;
  logic  func;
  word_t seed;

  modport source (output valid, output func, output seed, input ready);
  modport sink   (input valid, input func, input seed, output ready);
endinterface

interface swbmwc_out_if;
  import swbmwc_pkg::*;

  logic  valid;
  logic  ready;
  word_t random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

// ----- hw/rtl/swbmwc_step.sv -----
// ----------------------------------------------------------------------------
// swbmwc_step
// Next-state logic: one generate step or one reseed of the generator state.
// ----------------------------------------------------------------------------
module swbmwc_step (
  input  swbmwc_pkg::gen_state_t cur,
  input  logic                   func,
  input  swbmwc_pkg::word_t      seed,
  output swbmwc_pkg::gen_state_t nxt,
  output swbmwc_pkg::word_t      diff
);
  import swbmwc_pkg::*;

  word_t      sub_val;
  logic       b_gt;
  word_t      seed_b;
  word_t      seed_c;
  gen_state_t gen_st;
  gen_state_t seed_st;

  // subtract-with-borrow lag step
  assign sub_val = cur.lag_a + {{(WORD_W-1){1'b0}}, cur.borrow};
  assign b_gt    = cur.lag_b > sub_val;
  assign diff    = b_gt ? (cur.lag_b - sub_val) : (cur.lag_b - sub_val - SWB_OFFSET);

  always_comb begin
    gen_st.lag_a    = cur.lag_b;
    gen_st.lag_b    = cur.lag_c;
    gen_st.lag_c    = diff;
    gen_st.borrow   = ~b_gt;
    // 16x16 multiply plus carry half; fits in 31 bits
    gen_st.mwc_low  = (WORD_W'(MUL_LOW)  * WORD_W'(cur.mwc_low[15:0]))
                    + WORD_W'(cur.mwc_low[31:16]);
    gen_st.mwc_high = (WORD_W'(MUL_HIGH) * WORD_W'(cur.mwc_high[15:0]))
                    + WORD_W'(cur.mwc_high[31:16]);
  end

  // reseed: twelve times seed is eight times plus four times
  assign seed_b = INIT_B + {1'b0, seed[31:1]};
  assign seed_c = INIT_C + {seed[30:0], 1'b0};

  always_comb begin
    seed_st.lag_a    = INIT_A + seed;
    seed_st.lag_b    = seed_b;
    seed_st.lag_c    = seed_c;
    seed_st.borrow   = seed_b > seed_c;
    seed_st.mwc_low  = INIT_LOW + (SEED_MUL_LOW * seed);
    seed_st.mwc_high = INIT_HIGH - ({seed[28:0], 3'b000} + {seed[29:0], 2'b00});
  end

  assign nxt = (func == FUNC_SEED) ? seed_st : gen_st;

endmodule

// ----- hw/rtl/swb_mwc_random_generator_unit.sv -----
// ----------------------------------------------------------------------------
// swb_mwc_random_generator_unit
// 32-bit random word generator: subtract-with-borrow lags plus two MWC words.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries requests (func, seed). func = FUNC_GENERATE asks for the
//   next word; func = FUNC_SEED reloads all state from seed and returns no
//   word. out_chan carries one random_word for each generate request, in
//   request order.
//   Pipeline: request register -> state update (lag step, 16x16 MWC
//   multiplies) -> word register (three-way add of lag difference and MWC
//   words). One request is taken every cycle unless a stalled output
//   backs up all stages; the state update is a combinational recurrence
//   on the state register, so back-to-back requests run at full rate.
//   Reset (rst_n low, synchronous) empties all stages and loads the fixed
//   initial state; in_chan.ready is high right after reset.
//   When the receiver stalls, the word is held stable in the output
//   register and the earlier stages keep filling; in_chan.ready falls only
//   once every stage holds a waiting item. Seed requests retire from the
//   request register without waiting on the output side.
// ----------------------------------------------------------------------------
module swb_mwc_random_generator_unit (
  input logic           clk,
  input logic           rst_n,
  swbmwc_in_if.sink     in_chan,
  swbmwc_out_if.source  out_chan
);
  import swbmwc_pkg::*;

  // request stage
  logic       in_v_r;
  logic       func_r;
  word_t      seed_r;
  // generator state
  gen_state_t state_r;
  gen_state_t state_nxt;
  word_t      diff_nxt;
  // middle stage: new lag value and new MWC words
  logic       mid_v_r;
  word_t      diff_r;
  word_t      low_r;
  word_t      high_r;
  // output stage
  logic       out_v_r;
  word_t      word_r;
  word_t      word_nxt;

  logic out_load;
  logic mid_ready;
  logic in_adv;
  logic in_ready;
  logic gen_move;

  swbmwc_step u_step (
    .cur  (state_r),
    .func (func_r),
    .seed (seed_r),
    .nxt  (state_nxt),
    .diff (diff_nxt)
  );

  // Ready chain: each stage loads when empty or when it drains downstream
  assign out_load  = ~out_v_r | out_chan.ready;
  assign mid_ready = ~mid_v_r | out_load;
  assign in_adv    = in_v_r & ((func_r == FUNC_SEED) | mid_ready);
  assign in_ready  = ~in_v_r | in_adv;
  assign gen_move  = in_v_r & (func_r == FUNC_GENERATE) & mid_ready;

  // word = s + (low << 16) + high * 0xFFFF, the last as (high << 16) - high
  assign word_nxt = diff_r + {low_r[15:0], 16'h0000} + {high_r[15:0], 16'h0000} - high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      mid_v_r <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= STATE_RESET;
    end else begin
      if (in_ready) begin
        in_v_r <= in_chan.valid;
      end
      // advance or reseed the state as the request retires
      if (in_adv) begin
        state_r <= state_nxt;
      end
      if (mid_ready) begin
        mid_v_r <= gen_move;
      end
      if (out_load) begin
        out_v_r <= mid_v_r;
      end
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      func_r <= in_chan.func;
      seed_r <= in_chan.seed;
    end
    if (gen_move) begin
      diff_r <= diff_nxt;
      low_r  <= state_nxt.mwc_low;
      high_r <= state_nxt.mwc_high;
    end
    if (out_load && mid_v_r) begin
      word_r <= word_nxt;
    end
  end

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_v_r;
  assign out_chan.random_word = word_r;

endmodule

// ----- hw/rtl/swbmwc_checker.sv -----
// ----------------------------------------------------------------------------
// swbmwc_checker
// Port-level checks for the random word generator, bound to the top level.
// ----------------------------------------------------------------------------
module swbmwc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input swbmwc_pkg::word_t out_word
);
  import swbmwc_pkg::*;

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("random word changed while stalled");

  // Reset empties the output stage
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // Reset leaves the block ready for a request
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("not ready after reset");

  // Backpressure reaches the input only through a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("request refused while output drains");

endmodule

bind swb_mwc_random_generator_unit swbmwc_checker u_swbmwc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_word  (out_chan.random_word)
);

// ----- tb/swb_mwc_random_generator_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swb_mwc_random_generator_unit_tb
// Self-checking bench for the SWB/MWC random word generator.
// Requests run through a directed table first, then a long random stream of
// generate and seed requests. A shadow of the generator state predicts each
// word. Both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module swb_mwc_random_generator_unit_tb;
  import swbmwc_pkg::*;

  // Seed scrambling for the high MWC word, and the MWC combining multiplier
  localparam word_t SEED_MUL_HIGH = 32'd12;
  localparam word_t HALF_MASK     = 32'h0000_FFFF;

  localparam int RANDOM_REQS = 500;
  localparam int PAUSE_AT    = 250;   // sender waits for an empty pipe here
  localparam int DRAIN_CYCS  = 20;    // pipe is three stages deep
  localparam int CYCLE_LIMIT = 200000;

  // First word after reset (and after seeding with zero, which reloads the
  // very same state)
  localparam word_t FIRST_WORD = 32'hA459_8740;

  typedef struct {
    logic  func;
    word_t seed;
    bit    typed;   // word below is known by hand
    word_t word;
  } req_row_t;

  logic clk;
  logic rst_n;

  swbmwc_in_if  req_chan ();
  swbmwc_out_if word_chan ();

  swb_mwc_random_generator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan),
    .out_chan (word_chan)
  );

  gen_state_t gen_shadow;          // shadow copy of the generator state
  word_t      expected_words[$];   // words owed by the DUT, oldest first
  req_row_t   directed_reqs[$];
  int         error_count;
  int         cycle_count;
  word_t      got_expected;

  // --------------------------------------------------------------------------
  // Clock: 4 ns period
  // --------------------------------------------------------------------------
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // Shadow generator: advance by one request, return the word it gives
  // --------------------------------------------------------------------------
  function automatic word_t mwc_next(input word_t w, input logic [15:0] mul);
    return word_t'(mul) * word_t'(w[15:0]) + (w >> 16);
  endfunction

  task automatic step_generator(input logic func, input word_t seed,
                                output bit produced, output word_t word);
    word_t sum;
    word_t diff;
    if (func == FUNC_SEED) begin
      gen_shadow.lag_a    = INIT_A + seed;
      gen_shadow.lag_b    = INIT_B + (seed >> 1);
      gen_shadow.lag_c    = INIT_C + (seed << 1);
      gen_shadow.mwc_low  = INIT_LOW + SEED_MUL_LOW * seed;
      gen_shadow.mwc_high = INIT_HIGH - SEED_MUL_HIGH * seed;
      gen_shadow.borrow   = (gen_shadow.lag_b > gen_shadow.lag_c);
      produced = 1'b0;
      word     = '0;
    end else begin
      // compare against the wrapped sum, not a 33-bit one
      sum = gen_shadow.lag_a + word_t'(gen_shadow.borrow);
      if (gen_shadow.lag_b > sum) begin
        diff = gen_shadow.lag_b - sum;
        gen_shadow.borrow = 1'b0;
      end else begin
        diff = gen_shadow.lag_b - sum - SWB_OFFSET;
        gen_shadow.borrow = 1'b1;
      end
      gen_shadow.lag_a    = gen_shadow.lag_b;
      gen_shadow.lag_b    = gen_shadow.lag_c;
      gen_shadow.lag_c    = diff;
      gen_shadow.mwc_low  = mwc_next(gen_shadow.mwc_low, MUL_LOW);
      gen_shadow.mwc_high = mwc_next(gen_shadow.mwc_high, MUL_HIGH);
      word = diff + (gen_shadow.mwc_low << 16) + gen_shadow.mwc_high * HALF_MASK;
      produced = 1'b1;
    end
  endtask

  // Seed that loads the low MWC word with zero: solve
  // INIT_LOW + SEED_MUL_LOW * seed == 0 with a Newton inverse of the odd
  // multiplier (each pass doubles the number of correct bits).
  function automatic word_t zero_mwc_seed();
    word_t inv;
    inv = SEED_MUL_LOW;
    repeat (5) inv = inv * (32'd2 - SEED_MUL_LOW * inv);
    return (32'd0 - INIT_LOW) * inv;
  endfunction

  // --------------------------------------------------------------------------
  // Request side: hold the payload until taken, then predict
  // --------------------------------------------------------------------------
  task automatic send_request(input logic func, input word_t seed, input int gap,
                              input bit typed, input word_t typed_word);
    bit    produced;
    word_t word;
    if (gap > 0) begin
      req_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_chan.valid <= 1'b1;
    req_chan.func  <= func;
    req_chan.seed  <= seed;
    @(posedge clk);
    while (!req_chan.ready) @(posedge clk);
    step_generator(func, seed, produced, word);
    if (produced) expected_words.push_back(typed ? typed_word : word);
  endtask

  task automatic add_row(input logic func, input word_t seed,
                         input bit typed, input word_t word);
    req_row_t row;
    row.func  = func;
    row.seed  = seed;
    row.typed = typed;
    row.word  = word;
    directed_reqs.push_back(row);
  endtask

  // Gaps: quiet stretches of forty requests alternate with random idling
  function automatic int sender_gap(input int idx);
    if ((idx / 40) % 3 == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic  func;
    word_t seed;
    int    idx;

    rst_n           <= 1'b0;
    req_chan.valid  <= 1'b0;
    req_chan.func   <= FUNC_GENERATE;
    req_chan.seed   <= '0;
    gen_shadow      = STATE_RESET;
    error_count     = 0;

    // Directed table. Seed fields on generate rows are junk and must be
    // ignored; seeding with zero reloads the reset state.
    add_row(FUNC_GENERATE, 32'hFFFF_FFFF, 1'b1, FIRST_WORD);
    add_row(FUNC_GENERATE, 32'h0000_0000, 1'b0, '0);
    add_row(FUNC_GENERATE, 32'hDEAD_BEEF, 1'b0, '0);
    add_row(FUNC_SEED,     32'h0000_0000, 1'b0, '0);
    add_row(FUNC_GENERATE, 32'h1234_5678, 1'b1, FIRST_WORD);
    add_row(FUNC_SEED,     32'hFFFF_FFFF, 1'b0, '0);
    add_row(FUNC_GENERATE, 32'h0000_0000, 1'b0, '0);
    add_row(FUNC_GENERATE, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(FUNC_SEED,     32'h8000_0000, 1'b0, '0);
    add_row(FUNC_GENERATE, 32'h0000_0000, 1'b0, '0);
    // lag_a at all ones straight after the reload
    add_row(FUNC_SEED,     ~INIT_A,       1'b0, '0);
    add_row(FUNC_GENERATE, 32'h0000_0000, 1'b0, '0);
    add_row(FUNC_GENERATE, 32'h0000_0000, 1'b0, '0);
    // low MWC word loaded with zero must stay at zero
    add_row(FUNC_SEED,     zero_mwc_seed(), 1'b0, '0);
    add_row(FUNC_GENERATE, 32'h0000_0000, 1'b0, '0);
    add_row(FUNC_GENERATE, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(FUNC_GENERATE, 32'h0000_0000, 1'b0, '0);
    add_row(FUNC_SEED,     32'h0000_0001, 1'b0, '0);
    add_row(FUNC_GENERATE, 32'h0000_0000, 1'b0, '0);
    // back-to-back reloads, the last one wins
    add_row(FUNC_SEED,     32'hAAAA_AAAA, 1'b0, '0);
    add_row(FUNC_SEED,     32'h5555_5555, 1'b0, '0);
    add_row(FUNC_GENERATE, 32'h0000_0000, 1'b0, '0);
    add_row(FUNC_GENERATE, 32'hAAAA_AAAA, 1'b0, '0);

    // Hold reset low, then release it once
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idx = 0;
    foreach (directed_reqs[i]) begin
      send_request(directed_reqs[i].func, directed_reqs[i].seed,
                   $urandom_range(0, 17), directed_reqs[i].typed,
                   directed_reqs[i].word);
    end

    // Random stream: mostly generate requests, with reloads mixed in so the
    // lag and MWC words restart from many seeds
    for (idx = 0; idx < RANDOM_REQS; idx++) begin
      func = ($urandom_range(0, 9) == 0) ? FUNC_SEED : FUNC_GENERATE;
      case ($urandom_range(0, 9))
        0:       seed = '0;
        1:       seed = '1;
        2:       seed = zero_mwc_seed();
        3:       seed = word_t'(1) << $urandom_range(0, 31);
        default: seed = $urandom();
      endcase
      if (idx == PAUSE_AT) begin
        // Drop valid and let the pipe run dry before carrying on
        req_chan.valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
        send_request(func, seed, 0, 1'b0, '0);
      end else begin
        send_request(func, seed, sender_gap(idx), 1'b0, '0);
      end
    end
    req_chan.valid <= 1'b0;

    // Wait for the last words, then give the pipe time to show strays
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCS) @(posedge clk);

    if (expected_words.size() != 0) begin
      $error("%0d expected words never arrived", expected_words.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: stall for a random number of cycles before each word, with
  // quiet stretches offset from the sender's
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    int taken;
    word_chan.ready <= 1'b0;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = ((taken / 40) % 3 == 1) ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        word_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      word_chan.ready <= 1'b1;
      @(posedge clk);
      while (!(word_chan.valid && word_chan.ready)) @(posedge clk);
      taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each accepted word with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && word_chan.valid && word_chan.ready) begin
      if (expected_words.size() == 0) begin
        $error("random_word: none expected, actual %h", word_chan.random_word);
        error_count++;
      end else begin
        got_expected = expected_words.pop_front();
        if (word_chan.random_word !== got_expected) begin
          $error("random_word mismatch: expected %h, actual %h",
                 got_expected, word_chan.random_word);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
